// ===== rtl/oas_pkg.sv =====
// ----------------------------------------------------------------------------
// oas_pkg: shared types and constants for the obstacle avoid sequencer
// Holds the configuration record, item layouts and the phase encoding.
// ----------------------------------------------------------------------------
package oas_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned RANGE_W  = 10;
    localparam int unsigned HDG_W    = 16;
    localparam int unsigned SPEED_W  = 7;
    localparam int unsigned TURN_W   = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 24;

    localparam logic [TIME_W-1:0] REFRESH_MS = 32'd20;
    localparam logic [HDG_W-1:0]  TURN_DEG   = 16'd90;

    localparam logic [SPEED_W-1:0] CRUISE_SPEED_RST = 7'd0;
    localparam logic [TURN_W-1:0]  TURN_TIME_RST    = 16'd500;
    localparam logic [RANGE_W-1:0] STOP_DIST_RST    = 10'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRUISE_SPEED = 2'd0,
        CFG_TURN_TIME    = 2'd1,
        CFG_STOP_DIST    = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_START        = 4'd0,
        PH_SAMPLE_LEFT  = 4'd1,
        PH_RETURN_LEFT  = 4'd2,
        PH_PAUSE_LEFT   = 4'd3,
        PH_TURN_RIGHT   = 4'd4,
        PH_SAMPLE_RIGHT = 4'd5,
        PH_RETURN_RIGHT = 4'd6,
        PH_PAUSE_RIGHT  = 4'd7,
        PH_FINAL_TURN   = 4'd8,
        PH_RESUME       = 4'd9
    } t_phase;

    typedef struct packed {
        logic [SPEED_W-1:0] cruise_speed;
        logic [TURN_W-1:0]  turn_time_ms;
        logic [RANGE_W-1:0] stop_distance_cm;
    } t_cfg;

    typedef struct packed {
        logic signed [HDG_W-1:0] heading_deg;
        logic [RANGE_W-1:0]      range_cm;
        logic [TIME_W-1:0]       now_ms;
    } t_in_item;

    typedef struct packed {
        logic                    avoiding;
        logic signed [HDG_W-1:0] target_heading_deg;
        logic [SPEED_W-1:0]      speed_cmd;
    } t_out_item;

endpackage

// ===== rtl/oas_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// oas_cfg_regs: configuration register file
// Decodes register writes and holds cruise speed, turn time and stop distance.
// ----------------------------------------------------------------------------
module oas_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [oas_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [oas_pkg::CFG_DATA_W-1:0] i_wr_data,
    output oas_pkg::t_cfg                  o_cfg
);
    import oas_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_CRUISE_SPEED: n_cfg.cruise_speed     = i_wr_data[SPEED_W-1:0];
                CFG_TURN_TIME:    n_cfg.turn_time_ms     = i_wr_data[TURN_W-1:0];
                CFG_STOP_DIST:    n_cfg.stop_distance_cm = i_wr_data[RANGE_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cruise_speed     <= CRUISE_SPEED_RST;
            r_cfg.turn_time_ms     <= TURN_TIME_RST;
            r_cfg.stop_distance_cm <= STOP_DIST_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/oas_seq.sv =====
// ----------------------------------------------------------------------------
// oas_seq: avoidance sequencer state and next-state logic
// Refreshes the held distance, runs the ten-phase turn sequence, forms result.
// ----------------------------------------------------------------------------
module oas_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  oas_pkg::t_in_item  i_item,
    input  oas_pkg::t_cfg      i_cfg,
    output oas_pkg::t_out_item o_result
);
    import oas_pkg::*;

    t_phase                  r_phase, n_phase;
    logic                    r_active, n_active;
    logic [TIME_W-1:0]       r_phase_start, n_phase_start;
    logic [TIME_W-1:0]       r_sample_time, n_sample_time;
    logic [RANGE_W-1:0]      r_held, n_held;
    logic [RANGE_W-1:0]      r_left, n_left;
    logic [RANGE_W-1:0]      r_right, n_right;
    logic signed [HDG_W-1:0] r_target, n_target;
    logic [SPEED_W-1:0]      r_speed, n_speed;

    logic [TIME_W-1:0] sample_age;
    logic [TIME_W-1:0] phase_age;
    logic              phase_done;

    assign sample_age = i_item.now_ms - r_sample_time;
    assign phase_age  = i_item.now_ms - r_phase_start;
    assign phase_done = phase_age > {{(TIME_W-TURN_W){1'b0}}, i_cfg.turn_time_ms};

    always_comb begin
        n_phase       = r_phase;
        n_active      = r_active;
        n_phase_start = r_phase_start;
        n_sample_time = r_sample_time;
        n_held        = r_held;
        n_left        = r_left;
        n_right       = r_right;
        n_target      = r_target;
        n_speed       = r_speed;

        if (sample_age > REFRESH_MS) begin
            n_held        = i_item.range_cm;
            n_sample_time = i_item.now_ms;
        end

        if (!r_active) begin
            if (n_held > i_cfg.stop_distance_cm) begin
                n_speed  = i_cfg.cruise_speed;
                n_target = i_item.heading_deg;
            end else begin
                n_active = 1'b1;
                n_speed  = '0;
            end
        end else if (r_phase == PH_START) begin
            n_target      = r_target - TURN_DEG;
            n_phase       = PH_SAMPLE_LEFT;
            n_phase_start = i_item.now_ms;
        end else if (phase_done) begin
            n_phase_start = i_item.now_ms;
            unique case (r_phase)
                PH_SAMPLE_LEFT: begin
                    n_left  = i_item.range_cm;
                    n_phase = PH_RETURN_LEFT;
                end
                PH_RETURN_LEFT: begin
                    n_target = r_target + TURN_DEG;
                    n_phase  = PH_PAUSE_LEFT;
                end
                PH_PAUSE_LEFT: begin
                    n_phase = PH_TURN_RIGHT;
                end
                PH_TURN_RIGHT: begin
                    n_target = r_target + TURN_DEG;
                    n_phase  = PH_SAMPLE_RIGHT;
                end
                PH_SAMPLE_RIGHT: begin
                    n_right = i_item.range_cm;
                    n_phase = PH_RETURN_RIGHT;
                end
                PH_RETURN_RIGHT: begin
                    n_target = r_target - TURN_DEG;
                    n_phase  = PH_PAUSE_RIGHT;
                end
                PH_PAUSE_RIGHT: begin
                    n_phase = PH_FINAL_TURN;
                end
                PH_FINAL_TURN: begin
                    // ties turn right
                    if (r_left > r_right) begin
                        n_target = r_target - TURN_DEG;
                    end else begin
                        n_target = r_target + TURN_DEG;
                    end
                    n_phase = PH_RESUME;
                end
                default: begin
                    // resume cruising; final advance keeps the old stamp
                    n_phase_start = r_phase_start;
                    n_speed       = i_cfg.cruise_speed;
                    n_active      = 1'b0;
                    n_phase       = PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_START;
            r_active      <= 1'b0;
            r_phase_start <= '0;
            r_sample_time <= '0;
            r_held        <= '0;
            r_left        <= '0;
            r_right       <= '0;
            r_target      <= '0;
            r_speed       <= '0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_active      <= n_active;
            r_phase_start <= n_phase_start;
            r_sample_time <= n_sample_time;
            r_held        <= n_held;
            r_left        <= n_left;
            r_right       <= n_right;
            r_target      <= n_target;
            r_speed       <= n_speed;
        end
    end

    assign o_result.speed_cmd          = n_speed;
    assign o_result.target_heading_deg = n_target;
    assign o_result.avoiding           = n_active;

`ifndef NO_ASSERTIONS
    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> r_phase == PH_START)
        else $error("phase left nonzero while cruising");

    a_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_speed == '0)
        else $error("nonzero speed during avoidance");

    a_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_active && r_phase == PH_RESUME && phase_done
        |=> !r_active && r_phase == PH_START)
        else $error("sequence did not finish after the resume phase");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_active) && $stable(r_target) && $stable(r_phase))
        else $error("state moved without an item");
`endif

endmodule

// ===== rtl/obstacle_avoid_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// obstacle_avoid_sequencer_core: obstacle avoidance phase sequencer
// Timing: the accepting edge loads the input register; the state update then
//   runs into the result register on the edge where the item fires, which
//   waits while an earlier result stalls on the output.
// Throughput: one item per cycle while the result stream is not stalled.
// Reset: synchronous active-low; state clears, registers take their defaults.
// ----------------------------------------------------------------------------
module obstacle_avoid_sequencer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input item stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [31:0] now_ms, [41:32] range_cm, [57:42] heading_deg, [63:58] zero
    input  logic [oas_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [6:0] speed_cmd, [22:7] target_heading_deg, [23] avoiding
    output logic [oas_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [oas_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [oas_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import oas_pkg::*;

    t_cfg      cfg;
    t_in_item  in_item;
    t_out_item result;

    logic      r_in_vld;
    t_in_item  r_in_item;
    logic      r_out_vld;
    t_out_item r_out_item;

    logic fire;
    logic in_take;

    // Config is always accepted and lands at once; write only while no item
    // is in flight.
    assign o_cfg_ready = 1'b1;

    oas_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Unpack the stream word into fields.
    assign in_item.now_ms      = i_s_tdata[TIME_W-1:0];
    assign in_item.range_cm    = i_s_tdata[TIME_W+RANGE_W-1:TIME_W];
    assign in_item.heading_deg = i_s_tdata[TIME_W+RANGE_W+HDG_W-1:TIME_W+RANGE_W];

    // Process the held item whenever the result register is free or draining.
    assign fire       = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || fire;
    assign in_take    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= in_item;
        end
    end

    oas_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Result register: load on fire, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_item;

`ifndef NO_ASSERTIONS
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_m_tvalid)
        else $error("processed item produced no result");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !fire |=> r_in_vld && $stable(r_in_item))
        else $error("pending item lost");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_m_tready |-> !fire)
        else $error("result overwritten while stalled");
`endif

endmodule
